[src/rdf_pkg.sv]
// shared types and constants for the record deframer
package rdf_pkg;

	localparam int unsigned ByteW     = 8;
	localparam int unsigned WordW     = 16;
	localparam int unsigned CfgIndexW = 8;
	localparam int unsigned HdrIdxW   = 3;

	localparam logic [WordW-1:0] MarkerReset     = 16'h1010;
	localparam logic [WordW-1:0] MaxPayloadReset = 16'd1994;

	// configuration register indexes
	localparam logic [CfgIndexW-1:0] CfgMarker     = 8'd0;
	localparam logic [CfgIndexW-1:0] CfgMaxPayload = 8'd1;

	// header byte positions
	localparam logic [HdrIdxW-1:0] HdrLabelHi = 3'd0;
	localparam logic [HdrIdxW-1:0] HdrLabelLo = 3'd1;
	localparam logic [HdrIdxW-1:0] HdrKindHi  = 3'd2;
	localparam logic [HdrIdxW-1:0] HdrKindLo  = 3'd3;
	localparam logic [HdrIdxW-1:0] HdrLen0    = 3'd4;
	localparam logic [HdrIdxW-1:0] HdrLen1    = 3'd5;
	localparam logic [HdrIdxW-1:0] HdrLen2    = 3'd6;
	localparam logic [HdrIdxW-1:0] HdrLen3    = 3'd7;

	typedef enum logic [1:0] {
		OUT_PAYLOAD   = 2'd0,
		OUT_EMPTY     = 2'd1,
		OUT_BAD_LABEL = 2'd2,
		OUT_OVERSIZE  = 2'd3
	} outcome_t;

	typedef enum logic [1:0] {
		PH_HEADER     = 2'd0,
		PH_PAYLOAD    = 2'd1,
		PH_HEADER_BAD = 2'd2
	} phase_t;

	typedef struct packed {
		outcome_t         outcome;
		logic [WordW-1:0] kind;
		logic [ByteW-1:0] data;
		logic             last;
	} result_t;

	typedef struct packed {
		logic   halted;
		phase_t phase;
	} status_t;

endpackage

[src/rdf_in_stage.sv]
// input register stage for stream bytes
module rdf_in_stage (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [rdf_pkg::ByteW-1:0] stream_byte,
	input  logic                     advance,
	output logic                     valid_s1,
	output logic [rdf_pkg::ByteW-1:0] byte_s1
);

	// free slot when empty or being drained this cycle
	assign in_ready = !valid_s1 || advance;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// byte payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= stream_byte;
		end
	end

endmodule

[src/rdf_core.sv]
// header parse, label and length checks, payload tracking
module rdf_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic [rdf_pkg::ByteW-1:0] byte_in,
	input  logic [rdf_pkg::WordW-1:0] marker_word,
	input  logic [rdf_pkg::WordW-1:0] max_payload,
	output logic                      res_valid,
	output rdf_pkg::result_t          res,
	output rdf_pkg::status_t          status
);

	rdf_pkg::phase_t                phase_q, phase_d;
	logic                           halted_q, halted_d;
	logic [rdf_pkg::HdrIdxW-1:0]    idx_q, idx_d;
	logic [rdf_pkg::WordW-1:0]      kind_q, kind_d;
	logic [rdf_pkg::WordW-1:0]      len_lo_q, len_lo_d;
	logic                           len_hi_q, len_hi_d;
	logic [rdf_pkg::WordW-1:0]      left_q, left_d;
	logic                           in_header;
	logic                           hdr_done;
	logic                           label_bad;
	logic                           too_long;

	assign in_header = (phase_q != rdf_pkg::PH_PAYLOAD);
	assign hdr_done  = in_header && (idx_q == rdf_pkg::HdrLen3);
	assign label_bad = (phase_q == rdf_pkg::PH_HEADER_BAD);
	// upper length bytes nonzero, or low half above the limit
	assign too_long  = len_hi_d || (len_lo_q > max_payload);

	// header field capture and counters
	always_comb begin
		idx_d    = idx_q;
		kind_d   = kind_q;
		len_lo_d = len_lo_q;
		len_hi_d = len_hi_q;
		left_d   = left_q;
		if (!in_header) begin
			left_d = left_q - 1'b1;
			if (left_q == rdf_pkg::WordW'(1)) begin
				idx_d = '0;
			end
		end else begin
			idx_d = idx_q + 1'b1;
			case (idx_q) inside
				rdf_pkg::HdrKindHi: kind_d[15:8] = byte_in;
				rdf_pkg::HdrKindLo: kind_d[7:0]  = byte_in;
				rdf_pkg::HdrLen0: begin
					len_lo_d = {8'h00, byte_in};
					len_hi_d = 1'b0;
				end
				rdf_pkg::HdrLen1: len_lo_d[15:8] = byte_in;
				rdf_pkg::HdrLen2, rdf_pkg::HdrLen3: len_hi_d = len_hi_q || (byte_in != '0);
				default: ;
			endcase
			if (hdr_done) begin
				left_d = len_lo_q;
			end
		end
	end

	// next phase
	always_comb begin
		phase_d  = phase_q;
		halted_d = halted_q;
		unique case (phase_q) inside
			rdf_pkg::PH_PAYLOAD: begin
				if (left_q == rdf_pkg::WordW'(1)) begin
					phase_d = rdf_pkg::PH_HEADER;
				end
			end
			rdf_pkg::PH_HEADER, rdf_pkg::PH_HEADER_BAD: begin
				if (idx_q == rdf_pkg::HdrLabelHi) begin
					phase_d = (byte_in == marker_word[15:8]) ? rdf_pkg::PH_HEADER
						: rdf_pkg::PH_HEADER_BAD;
				end else if (idx_q == rdf_pkg::HdrLabelLo && byte_in != marker_word[7:0]) begin
					phase_d = rdf_pkg::PH_HEADER_BAD;
				end else if (hdr_done) begin
					if (label_bad || too_long) begin
						phase_d  = rdf_pkg::PH_HEADER;
						halted_d = 1'b1;
					end else if (len_lo_q == '0) begin
						phase_d = rdf_pkg::PH_HEADER;
					end else begin
						phase_d = rdf_pkg::PH_PAYLOAD;
					end
				end
			end
			default: phase_d = rdf_pkg::PH_HEADER;
		endcase
	end

	// result for this byte
	always_comb begin
		res_valid   = 1'b0;
		res.outcome = rdf_pkg::OUT_PAYLOAD;
		res.kind    = kind_q;
		res.data    = '0;
		res.last    = 1'b1;
		unique case (phase_q) inside
			rdf_pkg::PH_PAYLOAD: begin
				res_valid = en;
				res.data  = byte_in;
				res.last  = (left_q == rdf_pkg::WordW'(1));
			end
			rdf_pkg::PH_HEADER, rdf_pkg::PH_HEADER_BAD: begin
				// a header that opens a payload gives no result of its own
				res_valid = en && hdr_done && (label_bad || too_long || len_lo_q == '0);
				if (label_bad) begin
					res.outcome = rdf_pkg::OUT_BAD_LABEL;
				end else if (too_long) begin
					res.outcome = rdf_pkg::OUT_OVERSIZE;
				end else begin
					res.outcome = rdf_pkg::OUT_EMPTY;
				end
			end
			default: res_valid = 1'b0;
		endcase
		if (halted_q) begin
			res_valid = 1'b0;
		end
	end

	// state registers, frozen once halted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= rdf_pkg::PH_HEADER;
			halted_q <= 1'b0;
			idx_q    <= '0;
			kind_q   <= '0;
			len_lo_q <= '0;
			len_hi_q <= 1'b0;
			left_q   <= '0;
		end else if (en && !halted_q) begin
			phase_q  <= phase_d;
			halted_q <= halted_d;
			idx_q    <= idx_d;
			kind_q   <= kind_d;
			len_lo_q <= len_lo_d;
			len_hi_q <= len_hi_d;
			left_q   <= left_d;
		end
	end

	assign status.halted = halted_q;
	assign status.phase  = phase_q;

endmodule

[src/rdf_out_stage.sv]
// result register toward the receiver
module rdf_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             res_valid,
	input  rdf_pkg::result_t res,
	output logic             advance,
	input  logic             out_ready,
	output logic             out_valid,
	output rdf_pkg::result_t out_res
);

	// register may load when empty or emptied this cycle
	assign advance = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_res <= res;
		end
	end

endmodule

[src/record_deframer_unit.sv]
// top level of the length-prefixed record deframer
//
// Input channel: one stream byte per beat on in_valid/in_ready.
// Each record is two label bytes, two type bytes, a 4-byte little-endian
// length and then the payload. Header beats give no result; after the
// eighth header byte one result comes for an empty record or an error.
// Each payload byte gives one result carrying the record type; the last
// one has end_of_record set. A bad label or a length above max_payload
// gives an error result and the block then drops every byte until reset.
// Output channel: one result per beat on out_valid/out_ready.
// Configuration: cfg_valid/cfg_ready writes marker_word (index 0) or
// max_payload (index 1); other indexes are ignored. cfg_ready is always high.
// Path: an accepted byte waits in the input register, passes the parse step
// and its result loads into the result register whenever that register can
// advance. Throughput: one byte per cycle while the receiver does not stall,
// set by the single parse step between the two registers.
// Reset clears the parser to header position zero and loads the default
// marker and maximum length. When the receiver stalls, the result register
// holds and in_ready drops as soon as the input register holds a byte.
module record_deframer_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [rdf_pkg::ByteW-1:0]     stream_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    outcome,
	output logic [rdf_pkg::WordW-1:0]     record_kind,
	output logic [rdf_pkg::ByteW-1:0]     payload_byte,
	output logic                          end_of_record,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rdf_pkg::CfgIndexW-1:0] cfg_index,
	input  logic [rdf_pkg::WordW-1:0]     cfg_data
);

	logic [rdf_pkg::WordW-1:0] marker_q;
	logic [rdf_pkg::WordW-1:0] max_payload_q;
	logic                      advance;
	logic                      valid_s1;
	logic [rdf_pkg::ByteW-1:0] byte_s1;
	logic                      res_valid;
	rdf_pkg::result_t          res;
	rdf_pkg::result_t          out_res;
	rdf_pkg::status_t          status;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q      <= rdf_pkg::MarkerReset;
			max_payload_q <= rdf_pkg::MaxPayloadReset;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rdf_pkg::CfgMarker:     marker_q      <= cfg_data;
				rdf_pkg::CfgMaxPayload: max_payload_q <= cfg_data;
				default: ;
			endcase
		end
	end

	rdf_in_stage u_in (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.stream_byte (stream_byte),
		.advance     (advance),
		.valid_s1    (valid_s1),
		.byte_s1     (byte_s1)
	);

	rdf_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (valid_s1 && advance),
		.byte_in     (byte_s1),
		.marker_word (marker_q),
		.max_payload (max_payload_q),
		.res_valid   (res_valid),
		.res         (res),
		.status      (status)
	);

	rdf_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.advance   (advance),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_res   (out_res)
	);

	assign outcome       = out_res.outcome;
	assign record_kind   = out_res.kind;
	assign payload_byte  = out_res.data;
	assign end_of_record = out_res.last;

`ifndef NO_ASSERTIONS
	// once halted, stays halted until reset
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		status.halted |=> status.halted)
		else $error("halt flag cleared without reset");

	// a halted parser issues no new result
	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		status.halted |-> !res_valid)
		else $error("result produced while halted");

	// only payload beats may be non-final
	a_mid_is_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !end_of_record |-> outcome == rdf_pkg::OUT_PAYLOAD)
		else $error("non-final beat with non-payload outcome");

	// non-payload results carry zero data and end the record
	a_status_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && outcome != rdf_pkg::OUT_PAYLOAD |-> payload_byte == '0 && end_of_record)
		else $error("status beat with data or without end mark");

	// full pipe with stalled receiver takes no byte
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid && !out_ready |-> !in_ready)
		else $error("byte accepted with no room");
`endif

endmodule
